// ===== hdl/lir_pkg.sv =====
// lir_pkg: shared types and constants for the linear interpolation resampler
// used by every file under hdl; depends on nothing

package lir_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned STEP_W      = 22;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INTERP,
    ST_TAIL
  } lir_state_e;

  // one command from the front to the back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic                       interp;
    logic                       last;
  } lir_cmd_t;

endpackage

// ===== hdl/linear_interp_resampler_core.sv =====
// linear_interp_resampler_core: top level of the linear interpolation resampler
// depends on lir_pkg, lir_front, lir_queue and lir_back
//
//   channel   direction  handshake                ports
//   in        sink       in_valid_i / in_ready_o  in_sample_i, in_last_i
//   out       source     out_valid_o / out_ready_i out_sample_o, run_last_o, stream_end_o
//   cfg       sink       cfg_we_i, no wait        cfg_wdata_i (phase step, Q FRAC_BITS)
//
// the back makes at most one result per cycle while its output is not stalled: it takes
// an input's command, makes its outputs, closes its interval when a sample is held and
// closes a final interval when it is marked last. results pass through three registers
// (operand, multiply and rounding). reset is async and clears stream state and the step
// to 1.0. a stalled output freezes the back only; the front keeps taking input until the
// two-entry command queue is full.

module linear_interp_resampler_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] in_sample_i,
  input  logic                                in_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_o,
  output logic                                run_last_o,
  output logic                                stream_end_o,
  input  logic                                cfg_we_i,
  input  logic [lir_pkg::STEP_W-1:0]          cfg_wdata_i
);

  logic [lir_pkg::STEP_W-1:0] phase_step_q, phase_step_d;
  logic                       push_valid, push_ready;
  lir_pkg::lir_cmd_t          push_data;
  logic                       pop_valid, pop_ready;
  lir_pkg::lir_cmd_t          pop_data;

  assign phase_step_d = cfg_we_i ? cfg_wdata_i : phase_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= lir_pkg::STEP_W'(64'd1 << FRAC_BITS);
    end else begin
      phase_step_q <= phase_step_d;
    end
  end

  lir_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_sample_i  (in_sample_i),
    .in_last_i    (in_last_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  lir_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  lir_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .phase_step_i (phase_step_q),
    .cmd_valid_i  (pop_valid),
    .cmd_ready_o  (pop_ready),
    .cmd_i        (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_sample_o (out_sample_o),
    .run_last_o   (run_last_o),
    .stream_end_o (stream_end_o)
  );

endmodule

// ===== hdl/lir_front.sv =====
// lir_front: accepts source samples, tracks the held sample and turns each input
//   that has a held sample or is marked last into an interval command; depends on lir_pkg

module lir_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] in_sample_i,
  input  logic                                in_last_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output lir_pkg::lir_cmd_t                   push_data_o
);

  logic signed [lir_pkg::SAMPLE_W-1:0] prev_sample_q, prev_sample_d;
  logic                                prev_valid_q, prev_valid_d;
  logic                                accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  // a first sample that is not last only becomes the held sample
  assign push_valid_o       = in_valid_i && (prev_valid_q || in_last_i);
  assign push_data_o.a      = prev_sample_q;
  assign push_data_o.b      = in_sample_i;
  assign push_data_o.interp = prev_valid_q;
  assign push_data_o.last   = in_last_i;

  always_comb begin
    prev_sample_d = prev_sample_q;
    prev_valid_d  = prev_valid_q;
    if (accept) begin
      if (in_last_i) begin
        prev_sample_d = '0;
        prev_valid_d  = 1'b0;
      end else begin
        prev_sample_d = in_sample_i;
        prev_valid_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sample_q <= '0;
      prev_valid_q  <= 1'b0;
    end else begin
      prev_sample_q <= prev_sample_d;
      prev_valid_q  <= prev_valid_d;
    end
  end

endmodule

// ===== hdl/lir_queue.sv =====
// lir_queue: short command queue between front and back
// depends on lir_pkg for the command type and depth

module lir_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  lir_pkg::lir_cmd_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output lir_pkg::lir_cmd_t pop_data_o
);

  localparam int unsigned PtrW = (lir_pkg::QUEUE_DEPTH > 1) ? $clog2(lir_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(lir_pkg::QUEUE_DEPTH + 1);

  lir_pkg::lir_cmd_t entries_q [lir_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CntW'(lir_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(lir_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/lir_back.sv =====
// lir_back: walks the output positions of each interval and interpolates
//   through a registered multiply pipeline; depends on lir_pkg

module lir_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [lir_pkg::STEP_W-1:0]          phase_step_i,
  input  logic                                cmd_valid_i,
  output logic                                cmd_ready_o,
  input  lir_pkg::lir_cmd_t                   cmd_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_o,
  output logic                                run_last_o,
  output logic                                stream_end_o
);

  localparam int unsigned SW  = lir_pkg::SAMPLE_W;
  localparam int unsigned OW  = ((FRAC_BITS + 1 > lir_pkg::STEP_W) ?
                                 FRAC_BITS + 1 : lir_pkg::STEP_W) + 1;
  localparam int unsigned VW  = FRAC_BITS + SW + 2;
  localparam logic [OW-1:0] One     = {{(OW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [OW-1:0] Two     = One << 1;
  localparam logic [OW-1:0] MinStep = One >> 5;
  localparam logic [VW-1:0] RoundUp = {{(VW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

  // sequencer
  lir_pkg::lir_state_e state_q, state_d;
  logic [OW-1:0]       off_q, off_d;
  lir_pkg::lir_cmd_t   cur_q, cur_d;
  logic [OW-1:0]       step_ext, step_eff, off_sum;
  logic                off_lt_one, sum_lt_one, sum_lt_two;
  logic                adv, stall;
  logic                emit, emit_run_last, emit_end;
  logic                is_tail;

  // pipeline
  logic                 p1_valid_q;
  logic signed [SW-1:0] p1_base_q;
  logic signed [SW:0]   p1_diff_q;
  logic [FRAC_BITS-1:0] p1_frac_q;
  logic                 p1_run_last_q, p1_end_q;
  logic                 p2_valid_q;
  logic signed [VW-1:0] p2_v_q;
  logic                 p2_run_last_q, p2_end_q;
  logic                 out_valid_q;
  logic signed [SW-1:0] out_sample_q;
  logic                 out_run_last_q, out_end_q;

  logic signed [VW-1:0] base_scaled, prod, v_sum, v_round, v_shift;
  logic signed [SW:0]   diff;

  assign stall = out_valid_q && !out_ready_i;
  assign adv   = !stall;

  // tiny steps are clamped so an interval never holds more than 32 outputs
  assign step_ext   = OW'(phase_step_i);
  assign step_eff   = (step_ext < MinStep) ? MinStep : step_ext;
  assign off_sum    = off_q + step_eff;
  assign off_lt_one = (off_q < One);
  assign sum_lt_one = (off_sum < One);
  assign sum_lt_two = (off_sum < Two);
  assign is_tail    = (state_q == lir_pkg::ST_TAIL);

  // sequencer outputs
  always_comb begin
    cmd_ready_o   = 1'b0;
    emit          = 1'b0;
    emit_run_last = 1'b0;
    emit_end      = 1'b0;
    unique case (state_q)
      lir_pkg::ST_IDLE: begin
        cmd_ready_o = adv;
      end
      lir_pkg::ST_INTERP: begin
        emit = off_lt_one;
        // last of this input unless another position fits here or in the tail
        emit_run_last = !sum_lt_one && (!cur_q.last || !sum_lt_two);
        emit_end      = emit_run_last && cur_q.last;
      end
      lir_pkg::ST_TAIL: begin
        emit          = off_lt_one;
        emit_run_last = !sum_lt_one;
        emit_end      = !sum_lt_one;
      end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    off_d   = off_q;
    cur_d   = cur_q;
    unique case (state_q)
      lir_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cur_d   = cmd_i;
          state_d = cmd_i.interp ? lir_pkg::ST_INTERP : lir_pkg::ST_TAIL;
        end
      end
      lir_pkg::ST_INTERP: begin
        if (off_lt_one) begin
          off_d = off_sum;
        end else begin
          off_d   = off_q - One;
          state_d = cur_q.last ? lir_pkg::ST_TAIL : lir_pkg::ST_IDLE;
        end
      end
      lir_pkg::ST_TAIL: begin
        if (off_lt_one) begin
          off_d = off_sum;
        end else begin
          off_d   = '0;
          state_d = lir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lir_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lir_pkg::ST_IDLE;
      off_q       <= '0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      state_q     <= state_d;
      off_q       <= off_d;
      p1_valid_q  <= emit;
      p2_valid_q  <= p1_valid_q;
      out_valid_q <= p2_valid_q;
    end
  end

  // tail outputs repeat b: zero slope from base b
  assign diff = (SW+1)'(cur_q.b) - (SW+1)'(cur_q.a);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cur_q         <= cur_d;
      p1_base_q     <= is_tail ? cur_q.b : cur_q.a;
      p1_diff_q     <= is_tail ? '0 : diff;
      p1_frac_q     <= is_tail ? '0 : off_q[FRAC_BITS-1:0];
      p1_run_last_q <= emit_run_last;
      p1_end_q      <= emit_end;
      p2_v_q        <= v_sum;
      p2_run_last_q <= p1_run_last_q;
      p2_end_q      <= p1_end_q;
      out_sample_q  <= v_shift[SW-1:0];
      out_run_last_q <= p2_run_last_q;
      out_end_q     <= p2_end_q;
    end
  end

  // a * one + (b - a) * frac
  assign base_scaled = {{(VW-SW-FRAC_BITS){p1_base_q[SW-1]}}, p1_base_q, {FRAC_BITS{1'b0}}};
  assign prod        = p1_diff_q * $signed({1'b0, p1_frac_q});
  assign v_sum       = base_scaled + prod;

  // shift with truncation toward zero
  assign v_round = p2_v_q[VW-1] ? p2_v_q + $signed(RoundUp) : p2_v_q;
  assign v_shift = v_round >>> FRAC_BITS;

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign run_last_o   = out_run_last_q;
  assign stream_end_o = out_end_q;

endmodule

// ===== hdl/lir_checker.sv =====
// lir_checker: port-level checks on the resampler top level, bound to it below
// depends on lir_pkg and linear_interp_resampler_core

module lir_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic signed [lir_pkg::SAMPLE_W-1:0] in_sample_i,
  input logic                                in_last_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_o,
  input logic                                run_last_o,
  input logic                                stream_end_o
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_sample_o) &&
      $stable(run_last_o) && $stable(stream_end_o))
    else $error("output beat changed while stalled");

  // end of stream always closes the run of its input
  a_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_end_o |-> run_last_o)
    else $error("stream_end without run_last");

  // no result can be pending right out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  // a result must pass the queue, sequencer and output registers, so none right after reset
  a_no_early_out: assert property (@(posedge clk_i)
    $rose(rst_ni) |=> !out_valid_o [*2])
    else $error("output valid too soon after reset");

  // a waiting input beat keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_sample_i) &&
      $stable(in_last_i))
    else $error("input beat changed while waiting");

endmodule

bind linear_interp_resampler_core lir_checker u_lir_checker (.*);

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for linear_interp_resampler_core, steps and samples in,
// interpolated beats out; a directed table then random streams under several steps
// depends on lir_pkg and the rtl under hdl
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned SAMPLE_W = lir_pkg::SAMPLE_W;
  localparam int unsigned STEP_W = lir_pkg::STEP_W;
  localparam int unsigned FRAC_BITS = 16;
  localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
  localparam longint unsigned MIN_STEP = ONE_Q >> 5;
  localparam int unsigned MAX_RUN = 32;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_EVERY = 1250;
  localparam int unsigned RAND_PHASES = 7;
  localparam int unsigned PHASE_ITEMS = 51;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       run_last;
    logic                       stream_end;
  } resample_out_t;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_STEP
  } row_kind_e;

  // n_fixed < 0: expectation comes from the predictor
  typedef struct {
    row_kind_e     kind;
    int            value;
    logic          last;
    int            n_fixed;
    resample_out_t e0;
    resample_out_t e1;
  } stim_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] in_sample_i;
  logic                       in_last_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [SAMPLE_W-1:0] out_sample_o;
  logic                       run_last_o;
  logic                       stream_end_o;
  logic                       cfg_we_i;
  logic [STEP_W-1:0]          cfg_wdata_i;

  // predictor state
  logic [STEP_W-1:0]          step_reg;
  logic signed [SAMPLE_W-1:0] held_sample;
  logic                       held_valid;
  longint unsigned            phase_acc;

  resample_out_t step_outs[$];
  resample_out_t pending_outs[$];
  stim_row_t     dir_rows[$];

  int unsigned mismatches;
  int unsigned beats_seen;
  int unsigned items_sent;
  int unsigned steps_written;
  bit          src_fast;
  bit          sink_fast;

  linear_interp_resampler_core #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_sample_i (in_sample_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_sample_o(out_sample_o),
    .run_last_o  (run_last_o),
    .stream_end_o(stream_end_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic resample_out_t beat_of(logic signed [SAMPLE_W-1:0] s, logic rl,
                                            logic se);
    return {s, rl, se};
  endfunction

  // a + (b - a) * frac over ONE_Q, truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] lerp(logic signed [SAMPLE_W-1:0] a,
                                                      logic signed [SAMPLE_W-1:0] b,
                                                      longint unsigned frac);
    longint v;
    longint r;
    v = longint'(a) * longint'(ONE_Q) + (longint'(b) - longint'(a)) * longint'(frac);
    if (v < 0) r = -((-v) >> FRAC_BITS);
    else r = v >> FRAC_BITS;
    return r[SAMPLE_W-1:0];
  endfunction

  function automatic void resample_item(logic signed [SAMPLE_W-1:0] b, logic l);
    longint unsigned eff;
    int unsigned     n;
    int unsigned     m;
    eff = (longint'(step_reg) < MIN_STEP) ? MIN_STEP : longint'(step_reg);
    step_outs.delete();
    n = 0;
    if (held_valid) begin
      while (phase_acc < ONE_Q && n < MAX_RUN) begin
        step_outs.push_back(beat_of(lerp(held_sample, b, phase_acc), 1'b0, 1'b0));
        n++;
        phase_acc += eff;
      end
      phase_acc -= ONE_Q;
    end
    if (l) begin
      // final interval repeats the last sample
      m = 0;
      while (phase_acc < ONE_Q && m < MAX_RUN) begin
        step_outs.push_back(beat_of(b, 1'b0, 1'b0));
        m++;
        phase_acc += eff;
      end
      if (step_outs.size() != 0) step_outs[step_outs.size()-1].stream_end = 1'b1;
      held_sample = '0;
      held_valid  = 1'b0;
      phase_acc   = 0;
    end else begin
      held_sample = b;
      held_valid  = 1'b1;
    end
    if (step_outs.size() != 0) step_outs[step_outs.size()-1].run_last = 1'b1;
  endfunction

  function automatic void add_row(row_kind_e k, int v, logic l, int nf, resample_out_t e0,
                                  resample_out_t e1);
    stim_row_t r;
    r.kind    = k;
    r.value   = v;
    r.last    = l;
    r.n_fixed = nf;
    r.e0      = e0;
    r.e1      = e1;
    dir_rows.push_back(r);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(logic signed [SAMPLE_W-1:0] prior);
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return prior + 16'($urandom_range(0, 511)) - 16'd256;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 7))
      0: return STEP_W'(2048);
      1: return STEP_W'(2097152);
      2: return STEP_W'($urandom_range(0, 2047));
      3: return STEP_W'($urandom());
      4: return STEP_W'(ONE_Q);
      default: return STEP_W'($urandom_range(20000, 200000));
    endcase
  endfunction

  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic l, int nf,
                             resample_out_t e0, resample_out_t e1);
    int unsigned gap;
    if (items_sent % 32 == 0) src_fast = ($urandom_range(0, 3) == 0);
    gap = src_fast ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_sample_i <= s;
    in_last_i   <= l;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    resample_item(s, l);
    if (nf < 0) begin
      foreach (step_outs[k]) pending_outs.push_back(step_outs[k]);
    end else begin
      if (nf >= 1) pending_outs.push_back(e0);
      if (nf >= 2) pending_outs.push_back(e1);
    end
  endtask

  // step changes only once the block has drained
  task automatic write_step(logic [STEP_W-1:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_outs.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    step_reg = v;
    steps_written++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin : check_beat
      resample_out_t want;
      beats_seen++;
      if (pending_outs.size() == 0) begin
        note_error($sformatf("unexpected beat: sample %0d run_last %0b stream_end %0b",
                             out_sample_o, run_last_o, stream_end_o));
      end else begin
        want = pending_outs.pop_front();
        if (want.sample !== out_sample_o || want.run_last !== run_last_o ||
            want.stream_end !== stream_end_o) begin
          note_error($sformatf(
            "beat %0d: expected sample %0d run_last %0b stream_end %0b, got %0d %0b %0b",
            beats_seen, want.sample, want.run_last, want.stream_end,
            out_sample_o, run_last_o, stream_end_o));
        end
      end
    end
  end

  // output side: random backpressure plus a long hold every so often
  initial begin : sink
    int unsigned gap;
    int unsigned next_hold;
    out_ready_i = 1'b0;
    sink_fast   = 1'b0;
    next_hold   = 250;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (beats_seen % 40 == 0) sink_fast = ($urandom_range(0, 3) == 0);
      gap = sink_fast ? 0 : $urandom_range(0, 13);
      if (beats_seen >= next_hold) begin
        gap = HOLD_CYCLES;
        next_hold += HOLD_EVERY;
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  initial begin : stimulus
    logic signed [SAMPLE_W-1:0] s;
    logic [STEP_W-1:0]          v;
    int unsigned                stream_left;
    in_valid_i    = 1'b0;
    in_sample_i   = '0;
    in_last_i     = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    step_reg      = STEP_W'(ONE_Q);
    held_sample   = '0;
    held_valid    = 1'b0;
    phase_acc     = 0;
    items_sent    = 0;
    steps_written = 0;
    src_fast      = 1'b0;
    stream_left   = 0;
    s             = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // unit step after reset copies the previous sample through
    add_row(ROW_SAMPLE, -32768, 1'b0, 0, '0, '0);
    add_row(ROW_SAMPLE, 32767, 1'b0, 1, beat_of(-16'sd32768, 1'b1, 1'b0), '0);
    add_row(ROW_SAMPLE, -32768, 1'b0, 1, beat_of(16'sd32767, 1'b1, 1'b0), '0);
    add_row(ROW_SAMPLE, 0, 1'b0, 1, beat_of(-16'sd32768, 1'b1, 1'b0), '0);
    add_row(ROW_SAMPLE, 1, 1'b1, 2, beat_of(16'sd0, 1'b0, 1'b0), beat_of(16'sd1, 1'b1, 1'b1));
    // single-sample stream only emits its final interval
    add_row(ROW_SAMPLE, 5, 1'b1, 1, beat_of(16'sd5, 1'b1, 1'b1), '0);
    // zero step clamps to the tiny step, last sample gives the most beats
    add_row(ROW_STEP, 0, 1'b0, -1, '0, '0);
    add_row(ROW_SAMPLE, 100, 1'b0, 0, '0, '0);
    add_row(ROW_SAMPLE, -100, 1'b0, -1, '0, '0);
    add_row(ROW_SAMPLE, 32767, 1'b1, -1, '0, '0);
    // large step: one beat, then empty intervals and a last sample that emits nothing
    add_row(ROW_STEP, 2097152, 1'b0, -1, '0, '0);
    add_row(ROW_SAMPLE, 7, 1'b0, 0, '0, '0);
    add_row(ROW_SAMPLE, -7, 1'b0, 1, beat_of(16'sd7, 1'b1, 1'b0), '0);
    add_row(ROW_SAMPLE, 9, 1'b0, 0, '0, '0);
    add_row(ROW_SAMPLE, 11, 1'b1, 0, '0, '0);
    add_row(ROW_STEP, 4194303, 1'b0, -1, '0, '0);
    add_row(ROW_SAMPLE, 1000, 1'b0, 0, '0, '0);
    add_row(ROW_SAMPLE, -1000, 1'b1, -1, '0, '0);
    add_row(ROW_STEP, 98304, 1'b0, -1, '0, '0);
    add_row(ROW_SAMPLE, -32768, 1'b0, -1, '0, '0);
    add_row(ROW_SAMPLE, 32767, 1'b0, -1, '0, '0);
    add_row(ROW_SAMPLE, 32767, 1'b0, -1, '0, '0);
    add_row(ROW_SAMPLE, -32768, 1'b1, -1, '0, '0);
    add_row(ROW_STEP, 43691, 1'b0, -1, '0, '0);
    add_row(ROW_SAMPLE, 12345, 1'b0, -1, '0, '0);
    add_row(ROW_SAMPLE, -12345, 1'b1, -1, '0, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_STEP) begin
        write_step(STEP_W'(dir_rows[i].value));
      end else begin
        send_sample(16'(dir_rows[i].value), dir_rows[i].last, dir_rows[i].n_fixed,
                    dir_rows[i].e0, dir_rows[i].e1);
      end
    end

    // random streams; a phase may end mid-stream, the step change carries over
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: v = STEP_W'(2048);
        1: v = STEP_W'(2097152);
        default: v = pick_step();
      endcase
      write_step(v);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (stream_left == 0) begin
          stream_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3)
                                                    : $urandom_range(4, 60);
        end
        stream_left--;
        s = pick_sample(s);
        send_sample(s, stream_left == 0, -1, '0, '0);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_outs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d samples and %0d output beats over %0d step settings",
             items_sent, beats_seen, steps_written);
    $display("mismatching beats: %0d", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lir_pkg.sv
hdl/lir_front.sv
hdl/lir_queue.sv
hdl/lir_back.sv
hdl/linear_interp_resampler_core.sv
hdl/lir_checker.sv
bench/tb_top.sv
